[hdl/cimr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cimr_pkg: shared types and constants for the CAN id/mask route table
// Operation and status codes, item layouts and the stored route record.
// ----------------------------------------------------------------------------
package cimr_pkg;

    localparam int FUNC_W      = 3;
    localparam int ID_W        = 29;
    localparam int IDX_FIELD_W = 4;
    localparam int STATUS_W    = 2;
    localparam int HIT_W       = 4;
    localparam int ENT_W       = 5;
    localparam int CTR_W       = 32;

    localparam logic [FUNC_W-1:0] FUNC_FRAME  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SET_EN = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [ID_W-1:0] STD_LIMIT = 29'h0000_07FF;
    localparam logic [ID_W-1:0] EXT_LIMIT = 29'h1FFF_FFFF;

    // Results per frame are capped; the counter must hold the cap itself.
    localparam int RESULT_CAP = 16;
    localparam int HIT_CNT_W  = $clog2(RESULT_CAP + 1);

    typedef struct packed {
        logic [FUNC_W-1:0]      func;
        logic [ID_W-1:0]        identifier;
        logic [ID_W-1:0]        mask;
        logic                   id_type;
        logic [IDX_FIELD_W-1:0] entry_index;
        logic                   enable;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HIT_W-1:0]    hit_index;
        logic                matched;
        logic                last;
        logic [ENT_W-1:0]    entries_used;
        logic [CTR_W-1:0]    frames_seen;
        logic [CTR_W-1:0]    frames_unmatched;
    } rsp_t;

    typedef struct packed {
        logic [ID_W-1:0] ident;
        logic [ID_W-1:0] mask;
        logic            extended;
        logic            enabled;
    } entry_t;

endpackage

[hdl/can_id_mask_route_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_id_mask_route_table: CAN acceptance filter with an id/mask route table
// Frame: one table read and one compare per stored route, then the final
//   result; earlier hits leave during the compares. Remove: a read and a
//   shifting write per shifted route; set enable: a read and a write-back.
//   One item at a time: req_stall is high until the last result sits in the
//   output register, and a stalled output holds the sequencer. Reset empties
//   the table at once.
// ----------------------------------------------------------------------------
module can_id_mask_route_table #(
    parameter int ROUTES = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  cimr_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output cimr_pkg::rsp_t rsp
);
    import cimr_pkg::*;

    localparam int IDX_W = (ROUTES > 1) ? $clog2(ROUTES) : 1;
    localparam int CNT_W = $clog2(ROUTES + 1);
    localparam int CMP_W = (CNT_W > IDX_FIELD_W) ? CNT_W : IDX_FIELD_W;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,  // wait for an item
        S_EXEC  = 8'b0000_0010,  // decode and do the work that needs no table read
        S_READ  = 8'b0000_0100,  // table read in flight
        S_CMP   = 8'b0000_1000,  // compare one route against the frame
        S_SHIFT = 8'b0001_0000,  // write a route one slot down
        S_ENWR  = 8'b0010_0000,  // write back a route with a new enable bit
        S_EMIT  = 8'b0100_0000,  // hand over a single non-frame result
        S_FIN   = 8'b1000_0000   // hand over the final frame result
    } state_t;

    state_t                state_reg,      state_next;
    req_t                  op_reg,         op_next;
    logic [CNT_W-1:0]      ptr_reg,        ptr_next;
    logic [CNT_W-1:0]      count_reg,      count_next;
    logic [CTR_W-1:0]      seen_reg,       seen_next;
    logic [CTR_W-1:0]      unm_reg,        unm_next;
    logic [HIT_CNT_W-1:0]  hit_cnt_reg,    hit_cnt_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]      pend_idx_reg,   pend_idx_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [HIT_W-1:0]      res_hit_reg,    res_hit_next;
    logic                  rsp_valid_reg,  rsp_valid_next;
    rsp_t                  rsp_reg,        rsp_next;

    // Table port
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    entry_t           rd_data;

    // Shared datapath
    logic             route_hit;
    logic             out_free;
    logic [CNT_W-1:0] ptr_inc;
    logic [CNT_W-1:0] ptr_dec;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] src_first;
    logic [ID_W-1:0]  limit;
    logic             add_over;

    cimr_table #(
        .DEPTH (ROUTES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (ptr_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // The one compare unit: route vs. frame under the route's mask.
    assign route_hit = rd_data.enabled && (rd_data.extended == op_reg.id_type) &&
                       (((op_reg.identifier ^ rd_data.ident) & rd_data.mask) == '0);

    // Output register can take a result when empty or being drained.
    assign out_free = !rsp_valid_reg || !rsp_stall;

    assign ptr_inc   = ptr_reg + CNT_W'(1);
    assign ptr_dec   = ptr_reg - CNT_W'(1);
    assign idx_ext   = CMP_W'(op_reg.entry_index);
    assign cnt_ext   = CMP_W'(count_reg);
    assign src_first = idx_ext + CMP_W'(1);

    // Range check for add: standard ids and masks are limited to 11 bits.
    assign limit    = op_reg.id_type ? EXT_LIMIT : STD_LIMIT;
    assign add_over = (op_reg.identifier > limit) || (op_reg.mask > limit);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        ptr_next        = ptr_reg;
        count_next      = count_reg;
        seen_next       = seen_reg;
        unm_next        = unm_reg;
        hit_cnt_next    = hit_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        res_status_next = res_status_reg;
        res_hit_next    = res_hit_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;
        wr_en           = 1'b0;
        wr_addr         = ptr_reg[IDX_W-1:0];
        wr_data         = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                // Capture the item; the work starts next cycle.
                if (req_valid)
                begin
                    op_next    = req;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_status_next = ST_OK;
                res_hit_next    = '0;
                state_next      = S_EMIT;
                case (op_reg.func)
                    FUNC_FRAME:
                    begin
                        seen_next       = seen_reg + CTR_W'(1);
                        hit_cnt_next    = '0;
                        pend_valid_next = 1'b0;
                        ptr_next        = '0;
                        state_next      = (count_reg == '0) ? S_FIN : S_READ;
                    end
                    FUNC_ADD:
                    begin
                        // Range is checked before room.
                        if (add_over)
                        begin
                            res_status_next = ST_RANGE;
                        end
                        else if (count_reg >= CNT_W'(ROUTES))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en            = 1'b1;
                            wr_addr          = count_reg[IDX_W-1:0];
                            wr_data.ident    = op_reg.identifier;
                            wr_data.mask     = op_reg.mask;
                            wr_data.extended = op_reg.id_type;
                            wr_data.enabled  = 1'b1;
                            count_next       = count_reg + CNT_W'(1);
                            res_hit_next     = HIT_W'(count_reg);
                        end
                    end
                    FUNC_REMOVE:
                    begin
                        if (idx_ext >= cnt_ext)
                        begin
                            res_status_next = ST_RANGE;
                        end
                        else if (src_first < cnt_ext)
                        begin
                            // Shift later routes down, starting with the next one.
                            ptr_next   = CNT_W'(src_first);
                            state_next = S_READ;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    FUNC_SET_EN:
                    begin
                        if (idx_ext >= cnt_ext)
                        begin
                            res_status_next = ST_RANGE;
                        end
                        else
                        begin
                            ptr_next   = CNT_W'(op_reg.entry_index);
                            state_next = S_READ;
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        // Routes past the count are never read before written.
                        count_next = '0;
                    end
                    default:
                    begin
                        res_status_next = ST_RANGE;
                    end
                endcase
            end

            S_READ:
            begin
                case (op_reg.func)
                    FUNC_FRAME:  state_next = S_CMP;
                    FUNC_REMOVE: state_next = S_SHIFT;
                    default:     state_next = S_ENWR;
                endcase
            end

            S_CMP:
            begin
                // A new hit pushes out the pending one, and waits while the output is busy.
                if (!(route_hit && pend_valid_reg && !out_free))
                begin
                    if (route_hit)
                    begin
                        pend_valid_next = 1'b1;
                        pend_idx_next   = ptr_reg[IDX_W-1:0];
                        hit_cnt_next    = hit_cnt_reg + HIT_CNT_W'(1);
                        if (pend_valid_reg)
                        begin
                            rsp_valid_next            = 1'b1;
                            rsp_next.status           = ST_OK;
                            rsp_next.hit_index        = HIT_W'(pend_idx_reg);
                            rsp_next.matched          = 1'b1;
                            rsp_next.last             = 1'b0;
                            rsp_next.entries_used     = ENT_W'(count_reg);
                            rsp_next.frames_seen      = seen_reg;
                            rsp_next.frames_unmatched = unm_reg;
                        end
                    end
                    ptr_next = ptr_inc;
                    if ((ptr_inc == count_reg) ||
                        (route_hit && (hit_cnt_reg == HIT_CNT_W'(RESULT_CAP - 1))))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end

            S_SHIFT:
            begin
                wr_en    = 1'b1;
                wr_addr  = ptr_dec[IDX_W-1:0];
                wr_data  = rd_data;
                ptr_next = ptr_inc;
                if (ptr_inc < count_reg)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_EMIT;
                end
            end

            S_ENWR:
            begin
                wr_en           = 1'b1;
                wr_data         = rd_data;
                wr_data.enabled = op_reg.enable;
                state_next      = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_next.status           = res_status_reg;
                    rsp_next.hit_index        = res_hit_reg;
                    rsp_next.matched          = 1'b0;
                    rsp_next.last             = 1'b1;
                    rsp_next.entries_used     = ENT_W'(count_reg);
                    rsp_next.frames_seen      = seen_reg;
                    rsp_next.frames_unmatched = unm_reg;
                    state_next                = S_IDLE;
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_next.status           = ST_OK;
                    rsp_next.last             = 1'b1;
                    rsp_next.entries_used     = ENT_W'(count_reg);
                    rsp_next.frames_seen      = seen_reg;
                    if (pend_valid_reg)
                    begin
                        rsp_next.hit_index        = HIT_W'(pend_idx_reg);
                        rsp_next.matched          = 1'b1;
                        rsp_next.frames_unmatched = unm_reg;
                    end
                    else
                    begin
                        // No route matched: count it and report the new total.
                        unm_next                  = unm_reg + CTR_W'(1);
                        rsp_next.hit_index        = '0;
                        rsp_next.matched          = 1'b0;
                        rsp_next.frames_unmatched = unm_reg + CTR_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            seen_reg       <= '0;
            unm_reg        <= '0;
            hit_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            seen_reg       <= seen_next;
            unm_reg        <= unm_next;
            hit_cnt_reg    <= hit_cnt_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        ptr_reg        <= ptr_next;
        pend_idx_reg   <= pend_idx_next;
        res_status_reg <= res_status_next;
        res_hit_reg    <= res_hit_next;
        rsp_reg        <= rsp_next;
    end

endmodule

[hdl/cimr_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cimr_table: route storage
// One write port and one read port with registered read data, no reset.
// ----------------------------------------------------------------------------
module cimr_table #(
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  cimr_pkg::entry_t  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output cimr_pkg::entry_t  rd_data
);
    import cimr_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

[hdl/cimr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cimr_checker: port-level checks for the CAN route table
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module cimr_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input cimr_pkg::rsp_t rsp
);
    import cimr_pkg::*;

    logic             open_reg;
    logic [CTR_W-1:0] seen_hold_reg;

    // Track whether a frame's results are partly delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            seen_hold_reg <= '0;
        end
        else if (rsp_valid && !rsp_stall)
        begin
            open_reg      <= !rsp.last;
            seen_hold_reg <= rsp.frames_seen;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result item changed");

    a_mid_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> rsp.matched && (rsp.status == ST_OK))
        else $error("non-final result item is not a frame hit");

    a_mid_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> req_stall)
        else $error("new item taken while a frame is still reporting");

    a_open_same_frame: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && open_reg |-> rsp.matched && (rsp.frames_seen == seen_hold_reg))
        else $error("frame results interleaved with another item");

    // Until the final result of an open frame is in the output register,
    // the block must not take a new item.
    a_no_req_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg && !(rsp_valid && rsp.last) && req_valid |-> req_stall)
        else $error("item accepted before frame results were complete");

endmodule

bind can_id_mask_route_table cimr_checker u_checker (.*);

[sim/route_filter_check_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_filter_check_pkg: expected-result tracking for the CAN route table
// Keeps a mirror of the route table and frame counters, works out the results
// each accepted item must produce, and checks returned results in order.
// ----------------------------------------------------------------------------
package route_filter_check_pkg;
    import cimr_pkg::*;

    localparam int ROUTE_SLOTS  = 16;
    localparam int REPORT_LIMIT = 40;

    class route_filter_checker;
        entry_t           routes [ROUTE_SLOTS];
        int unsigned      table_fill;
        logic [CTR_W-1:0] seen_count;
        logic [CTR_W-1:0] unmatched_count;
        rsp_t             awaited_results [$];
        int unsigned      mismatch_count;

        function new();
            foreach (routes[k])
                routes[k] = '0;
            table_fill      = 0;
            seen_count      = '0;
            unmatched_count = '0;
            mismatch_count  = 0;
        endfunction

        // Counters and table size are the values after the operation.
        function void owe_result(logic [STATUS_W-1:0] status, int unsigned hit,
                                 logic matched, logic last);
            rsp_t r;
            r.status           = status;
            r.hit_index        = HIT_W'(hit);
            r.matched          = matched;
            r.last             = last;
            r.entries_used     = ENT_W'(table_fill);
            r.frames_seen      = seen_count;
            r.frames_unmatched = unmatched_count;
            awaited_results.push_back(r);
        endfunction

        function void apply_request(req_t r);
            int unsigned     hits [$];
            logic [ID_W-1:0] limit;
            int unsigned     k;
            case (r.func)
                FUNC_FRAME:
                begin
                    seen_count++;
                    for (k = 0; k < table_fill; k++)
                        if (routes[k].enabled && routes[k].extended == r.id_type &&
                            (r.identifier & routes[k].mask) ==
                            (routes[k].ident & routes[k].mask) &&
                            hits.size() < RESULT_CAP)
                            hits.push_back(k);
                    if (hits.size() == 0)
                    begin
                        unmatched_count++;
                        owe_result(ST_OK, 0, 1'b0, 1'b1);
                    end
                    else
                    begin
                        foreach (hits[n])
                            owe_result(ST_OK, hits[n], 1'b1, n == hits.size() - 1);
                    end
                end
                FUNC_ADD:
                begin
                    limit = r.id_type ? EXT_LIMIT : STD_LIMIT;
                    // range check wins over the room check
                    if (r.identifier > limit || r.mask > limit)
                        owe_result(ST_RANGE, 0, 1'b0, 1'b1);
                    else if (table_fill >= ROUTE_SLOTS)
                        owe_result(ST_FULL, 0, 1'b0, 1'b1);
                    else
                    begin
                        routes[table_fill].ident    = r.identifier;
                        routes[table_fill].mask     = r.mask;
                        routes[table_fill].extended = r.id_type;
                        routes[table_fill].enabled  = 1'b1;
                        table_fill++;
                        owe_result(ST_OK, table_fill - 1, 1'b0, 1'b1);
                    end
                end
                FUNC_REMOVE:
                begin
                    if (r.entry_index >= table_fill)
                        owe_result(ST_RANGE, 0, 1'b0, 1'b1);
                    else
                    begin
                        for (k = 32'(r.entry_index); k + 1 < table_fill; k++)
                            routes[k] = routes[k + 1];
                        table_fill--;
                        routes[table_fill] = '0;
                        owe_result(ST_OK, 0, 1'b0, 1'b1);
                    end
                end
                FUNC_SET_EN:
                begin
                    if (r.entry_index >= table_fill)
                        owe_result(ST_RANGE, 0, 1'b0, 1'b1);
                    else
                    begin
                        routes[r.entry_index].enabled = r.enable;
                        owe_result(ST_OK, 0, 1'b0, 1'b1);
                    end
                end
                FUNC_CLEAR:
                begin
                    foreach (routes[j])
                        routes[j] = '0;
                    table_fill = 0;
                    owe_result(ST_OK, 0, 1'b0, 1'b1);
                end
                default:
                    owe_result(ST_RANGE, 0, 1'b0, 1'b1);
            endcase
        endfunction

        task report_mismatch(string msg);
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("[%0t] MISMATCH %s", $time, msg);
        endtask

        task compare_field(string name, logic [CTR_W-1:0] got, logic [CTR_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_result(rsp_t got);
            rsp_t want;
            if (awaited_results.size() == 0)
            begin
                report_mismatch($sformatf("result 0x%0h arrived with none outstanding", got));
                return;
            end
            want = awaited_results.pop_front();
            compare_field("status", CTR_W'(got.status), CTR_W'(want.status));
            compare_field("hit_index", CTR_W'(got.hit_index), CTR_W'(want.hit_index));
            compare_field("matched", CTR_W'(got.matched), CTR_W'(want.matched));
            compare_field("last", CTR_W'(got.last), CTR_W'(want.last));
            compare_field("entries_used", CTR_W'(got.entries_used),
                          CTR_W'(want.entries_used));
            compare_field("frames_seen", got.frames_seen, want.frames_seen);
            compare_field("frames_unmatched", got.frames_unmatched, want.frames_unmatched);
        endtask
    endclass

endpackage

[sim/can_id_mask_route_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_id_mask_route_table_tb: self-checking bench for the CAN route table
// Drives a short directed list (range limits, every operation, match and
// no-match frames, shifting removes), then random items with frames built
// mostly from stored routes, plus bursts that fill the table and hit every
// route at once. A mirror of the table predicts each result; both handshakes
// idle at random except in the last, full-rate phase.
// ----------------------------------------------------------------------------
module can_id_mask_route_table_tb;
    import cimr_pkg::*;
    import route_filter_check_pkg::*;

    // The limit leaves room for a 16-hit frame and long random stalls.
    localparam int WATCHDOG_LIMIT         = 2000;
    localparam int DRAIN_CYCLES           = 80;
    localparam int RESET_CYCLES           = 11;
    localparam int RANDOM_ITEMS_PER_PHASE = 40;

    // Operation codes the block does not define; they must come back out of range.
    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN_LO = FUNC_CLEAR + 1'b1;
    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN_HI = '1;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned quiet_cycles       = 0;

    route_filter_checker route_mirror;

    can_id_mask_route_table #(
        .ROUTES (ROUTE_SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    // Hold off results at random; the rate follows the current phase.
    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < receiver_stall_pct);

    // Sample both handshakes at the edge: check results before noting the new
    // item so a result still in the output register pairs with its own item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                route_mirror.check_result(rsp);
            if (req_valid && !req_stall)
                route_mirror.apply_request(req);
            if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Fill every field with noise; callers overwrite what the operation uses.
    function automatic req_t scrambled_req();
        req_t r;
        r.func        = FUNC_W'($urandom);
        r.identifier  = ID_W'($urandom);
        r.mask        = ID_W'($urandom);
        r.id_type     = 1'($urandom);
        r.entry_index = IDX_FIELD_W'($urandom);
        r.enable      = 1'($urandom);
        return r;
    endfunction

    function automatic req_t compose_req(logic [FUNC_W-1:0] func, logic [ID_W-1:0] ident,
                                         logic [ID_W-1:0] mask, logic ext,
                                         logic [IDX_FIELD_W-1:0] idx, logic en);
        req_t r;
        r.func        = func;
        r.identifier  = ident;
        r.mask        = mask;
        r.id_type     = ext;
        r.entry_index = idx;
        r.enable      = en;
        return r;
    endfunction

    // Idle a random number of cycles, then present the item and hold it until
    // it is taken. Valid is only lowered in cycles where it stays low.
    task automatic send_item(input req_t r);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic send_random_item();
        req_t            r;
        int unsigned     pick;
        int unsigned     k;
        logic [ID_W-1:0] limit;
        r     = scrambled_req();
        pick  = $urandom_range(99);
        limit = r.id_type ? EXT_LIMIT : STD_LIMIT;
        if (pick < 40)
        begin
            r.func = FUNC_FRAME;
            if (route_mirror.table_fill > 0 && $urandom_range(9) < 7)
            begin
                // Keep the compared bits of a stored route, scramble the rest.
                k         = $urandom_range(route_mirror.table_fill - 1);
                r.id_type = route_mirror.routes[k].extended;
                limit     = r.id_type ? EXT_LIMIT : STD_LIMIT;
                if ($urandom_range(9) == 0)
                    limit = EXT_LIMIT;
                r.identifier = route_mirror.routes[k].ident ^
                               (ID_W'($urandom) & ~route_mirror.routes[k].mask & limit);
            end
            else if (!r.id_type && $urandom_range(3) != 0)
                r.identifier &= STD_LIMIT;
        end
        else if (pick < 70)
        begin
            r.func = FUNC_ADD;
            // Mostly legal routes; the raw noise case tests the range check.
            if ($urandom_range(9) != 0)
            begin
                r.identifier &= limit;
                case ($urandom_range(3))
                    0:       r.mask = '0;
                    1:       r.mask = limit;
                    default: r.mask &= limit;
                endcase
            end
        end
        else if (pick < 92)
        begin
            r.func = (pick < 80) ? FUNC_REMOVE : FUNC_SET_EN;
            if (route_mirror.table_fill > 0 && $urandom_range(9) < 8)
                r.entry_index = IDX_FIELD_W'($urandom_range(route_mirror.table_fill - 1));
        end
        else if (pick < 96)
            r.func = FUNC_CLEAR;
        else
            r.func = FUNC_W'($urandom_range(FUNC_UNKNOWN_HI, FUNC_UNKNOWN_LO));
        send_item(r);
    endtask

    // Clear, add one route past capacity, then send a frame that hits every
    // route and one with a random id. Each route differs from the base id only
    // in bits its own mask ignores.
    task automatic send_full_table_burst();
        req_t            r;
        logic [ID_W-1:0] base;
        logic [ID_W-1:0] limit;
        logic [ID_W-1:0] diff;
        logic            ext;
        int              k;
        ext   = 1'($urandom);
        limit = ext ? EXT_LIMIT : STD_LIMIT;
        base  = ID_W'($urandom) & limit;
        r      = scrambled_req();
        r.func = FUNC_CLEAR;
        send_item(r);
        for (k = 0; k < ROUTE_SLOTS + 1; k++)
        begin
            diff         = ID_W'($urandom) & limit;
            r            = scrambled_req();
            r.func       = FUNC_ADD;
            r.id_type    = ext;
            r.identifier = base ^ diff;
            r.mask       = ID_W'($urandom) & ~diff & limit;
            send_item(r);
        end
        r            = scrambled_req();
        r.func       = FUNC_FRAME;
        r.id_type    = ext;
        r.identifier = base;
        send_item(r);
        r.identifier = base ^ (ID_W'($urandom) & limit);
        send_item(r);
    endtask

    initial
    begin
        int phase;
        int f;
        route_mirror = new();
        sender_idle_pct    = 25;
        receiver_stall_pct = 71;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: frame on the empty table, then range limits of add.
        send_item(compose_req(FUNC_FRAME, '0, '0, 1'b0, 4'd0, 1'b0));
        send_item(compose_req(FUNC_ADD, STD_LIMIT, STD_LIMIT, 1'b0, 4'd0, 1'b0));
        send_item(compose_req(FUNC_ADD, STD_LIMIT + 1'b1, '0, 1'b0, 4'd0, 1'b0));
        send_item(compose_req(FUNC_ADD, '0, EXT_LIMIT, 1'b0, 4'd0, 1'b0));
        send_item(compose_req(FUNC_ADD, EXT_LIMIT, EXT_LIMIT, 1'b1, 4'hF, 1'b1));
        send_item(compose_req(FUNC_ADD, '0, '0, 1'b1, 4'd0, 1'b0));
        // Exact match, double match, near miss, standard frame with high bits set.
        send_item(compose_req(FUNC_FRAME, STD_LIMIT, '0, 1'b0, 4'd0, 1'b0));
        send_item(compose_req(FUNC_FRAME, EXT_LIMIT, '0, 1'b1, 4'd0, 1'b0));
        send_item(compose_req(FUNC_FRAME, STD_LIMIT - 1'b1, '0, 1'b0, 4'd0, 1'b0));
        send_item(compose_req(FUNC_FRAME, EXT_LIMIT, '0, 1'b0, 4'd0, 1'b0));
        // Disable a route, confirm it drops out, restore it.
        send_item(compose_req(FUNC_SET_EN, '0, '0, 1'b0, 4'd1, 1'b0));
        send_item(compose_req(FUNC_FRAME, EXT_LIMIT, '0, 1'b1, 4'd0, 1'b0));
        send_item(compose_req(FUNC_SET_EN, '0, '0, 1'b0, 4'hF, 1'b1));
        send_item(compose_req(FUNC_SET_EN, '0, '0, 1'b0, 4'd1, 1'b1));
        // Remove past the end, then remove the head and let the rest shift down.
        send_item(compose_req(FUNC_REMOVE, '0, '0, 1'b0, 4'd3, 1'b0));
        send_item(compose_req(FUNC_REMOVE, '0, '0, 1'b0, 4'd0, 1'b0));
        send_item(compose_req(FUNC_FRAME, EXT_LIMIT, '0, 1'b1, 4'd0, 1'b0));
        for (f = FUNC_UNKNOWN_LO; f <= FUNC_UNKNOWN_HI; f++)
            send_item(compose_req(FUNC_W'(f), EXT_LIMIT, EXT_LIMIT, 1'b1, 4'hF, 1'b1));
        send_item(compose_req(FUNC_CLEAR, '0, '0, 1'b0, 4'd0, 1'b0));
        send_item(compose_req(FUNC_FRAME, EXT_LIMIT, '0, 1'b1, 4'd0, 1'b0));
        send_item(compose_req(FUNC_REMOVE, '0, '0, 1'b0, 4'd0, 1'b0));

        // Random: receiver-side stalls first, then sender-side gaps, then full rate.
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 25;
                    receiver_stall_pct = 71;
                end
                1:
                begin
                    sender_idle_pct    = 71;
                    receiver_stall_pct = 25;
                end
                default:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            send_full_table_burst();
            repeat (RANDOM_ITEMS_PER_PHASE)
                send_random_item();
        end
        req_valid <= 1'b0;

        // Drain: wait for every owed result, then watch for stray ones.
        while (route_mirror.awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (route_mirror.mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
